>>> rtl/core/i2cm_pkg.sv
// Package for the I2C master bit engine: command codes, result type and helpers.
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int HOLD_COUNT_WIDTH_DEFAULT = 16;
   localparam logic [15:0] HOLD_TICKS_RESET = 16'd10;

   localparam int OP_WIDTH = 3;
   localparam int IDX_WIDTH = 5;

   // Command codes; the tick-only code and the unused code start nothing.
   localparam logic [OP_WIDTH-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_START = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_STOP  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_WRITE = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_SACK  = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_RACK  = 3'd6;

   // One result item, as the engine hands it to the output register.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       rx_ack;
   } rsp_type;

   // Number of pin actions in each command's list.
   function automatic logic [IDX_WIDTH-1:0] list_length(input logic [OP_WIDTH-1:0] cmd);
      logic [IDX_WIDTH-1:0] len;
      unique case (cmd)
         OP_START: len = 5'd4;
         OP_STOP:  len = 5'd3;
         OP_WRITE: len = 5'd24;
         OP_READ:  len = 5'd25;
         OP_SACK:  len = 5'd3;
         OP_RACK:  len = 5'd4;
         default:  len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/core/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: request register, engine and response register.
`timescale 1ns / 1ps

// Open-drain I2C master bit engine. Each request is one timing tick, carrying
// an optional command (start, stop, write byte, read byte, send ack, receive
// ack) and the sampled SDA level. A command is taken only while the engine is
// idle; it then runs its fixed list of pin actions, one action per tick with
// hold_ticks ticks between actions, and raises done_res on the completing tick.
// Every request yields exactly one response showing the pin levels and status
// after that tick. Throughput is one request per clock while neither req_stall
// nor rsp_stall holds the flow: the request register feeds single-pass step
// logic whose outcome lands in the response register. While a response waits,
// the request register takes one further request and then stalls the sender.
// hold_ticks is to be written through the csr_ port (always ready) only while
// idle; the block itself does not enforce this.
module i2c_master_bit_engine #(
   parameter int HOLD_COUNT_WIDTH = i2cm_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [i2cm_pkg::OP_WIDTH-1:0] req_op,
   input  logic [7:0]                    req_tx_data,
   input  logic                          req_ack_out,
   input  logic                          req_sda_in,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_scl_out,
   output logic                          rsp_sda_out,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [7:0]                    rsp_rx_data,
   output logic                          rsp_rx_ack,
   // Configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_hold_ticks
);

   logic                          req_valid_ff;
   logic [i2cm_pkg::OP_WIDTH-1:0] op_ff;
   logic [7:0]                    tx_ff;
   logic                          ack_ff;
   logic                          sdi_ff;
   logic [15:0]                   hold_ticks_ff;
   logic                          rsp_valid_ff;
   i2cm_pkg::rsp_type             rsp_ff;
   i2cm_pkg::rsp_type             step_rsp;
   logic                          advance;
   logic                          req_take;

   // Advance the held request whenever the response register is free or draining.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Hold the request until the engine takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_op;
         tx_ff  <= req_tx_data;
         ack_ff <= req_ack_out;
         sdi_ff <= req_sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= i2cm_pkg::HOLD_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         hold_ticks_ff <= csr_hold_ticks;
      end
   end

   i2cm_engine #(
      .HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .op         (op_ff),
      .tx_data    (tx_ff),
      .ack_out    (ack_ff),
      .sda_in     (sdi_ff),
      .hold_ticks (hold_ticks_ff),
      .result     (step_rsp)
   );

   // Response register: load on advance, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_scl_out  = rsp_ff.scl_out;
   assign rsp_sda_out  = rsp_ff.sda_out;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_rx_data  = rsp_ff.rx_data;
   assign rsp_rx_ack   = rsp_ff.rx_ack;

endmodule

>>> rtl/core/i2cm_engine.sv
// Command state and per-tick step logic of the I2C master bit engine.
`timescale 1ns / 1ps

module i2cm_engine #(
   parameter int HOLD_COUNT_WIDTH = i2cm_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step_en,
   input  logic [i2cm_pkg::OP_WIDTH-1:0]      op,
   input  logic [7:0]                         tx_data,
   input  logic                               ack_out,
   input  logic                               sda_in,
   input  logic [15:0]                        hold_ticks,
   output i2cm_pkg::rsp_type                  result
);

   localparam int CW = (HOLD_COUNT_WIDTH > 16) ? HOLD_COUNT_WIDTH : 16;
   localparam logic [HOLD_COUNT_WIDTH-1:0] HOLD_MAX = {HOLD_COUNT_WIDTH{1'b1}};
   localparam logic [HOLD_COUNT_WIDTH-1:0] HOLD_ONE = HOLD_COUNT_WIDTH'(1);

   logic                                scl_ff, scl_in;
   logic                                sda_ff, sda_in_lvl;
   logic [i2cm_pkg::OP_WIDTH-1:0]       cmd_ff, cmd_in;
   logic [i2cm_pkg::IDX_WIDTH-1:0]      idx_ff, idx_in;
   logic [1:0]                          phase_ff, phase_in;
   logic [7:0]                          shift_ff, shift_in;
   logic [HOLD_COUNT_WIDTH-1:0]         hold_ff, hold_in;
   logic                                ack_ff, ack_in;
   logic                                busy_ff, busy_in;
   logic [7:0]                          rx_ff, rx_in;
   logic                                done;
   logic                                act;
   logic [HOLD_COUNT_WIDTH-1:0]         hold_load;
   logic [CW-1:0]                       ticks_ext;

   // Saturate the hold setting to what the counter can hold.
   always_comb begin
      ticks_ext = CW'(hold_ticks);
      if (ticks_ext > CW'(HOLD_MAX)) begin
         hold_load = HOLD_MAX;
      end else begin
         hold_load = ticks_ext[HOLD_COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      ack_in     = ack_ff;
      busy_in    = busy_ff;
      hold_in    = hold_ff;
      rx_in      = rx_ff;
      done       = 1'b0;
      act        = 1'b0;

      if (!busy_ff) begin
         if (op >= i2cm_pkg::OP_START && op <= i2cm_pkg::OP_RACK) begin
            cmd_in   = op;
            idx_in   = '0;
            phase_in = 2'd0;
            if (op == i2cm_pkg::OP_WRITE) begin
               shift_in = tx_data;
            end else if (op == i2cm_pkg::OP_SACK) begin
               shift_in = {7'd0, ack_out};
            end else begin
               shift_in = 8'd0;
            end
            busy_in = 1'b1;
            act     = 1'b1;
         end
      end else if (hold_ff > HOLD_ONE) begin
         hold_in = hold_ff - HOLD_ONE;
      end else begin
         hold_in = '0;
         if (idx_ff >= i2cm_pkg::list_length(cmd_ff)) begin
            if (cmd_ff == i2cm_pkg::OP_READ) begin
               rx_in = shift_ff;
            end
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            act = 1'b1;
         end
      end

      if (act) begin
         unique case (cmd_in)
            i2cm_pkg::OP_START: begin
               unique case (idx_in)
                  5'd0:    sda_in_lvl = 1'b1;
                  5'd1:    scl_in = 1'b1;
                  5'd2:    sda_in_lvl = 1'b0;
                  default: scl_in = 1'b0;
               endcase
            end
            i2cm_pkg::OP_STOP: begin
               unique case (idx_in)
                  5'd0:    sda_in_lvl = 1'b0;
                  5'd1:    scl_in = 1'b1;
                  default: sda_in_lvl = 1'b1;
               endcase
            end
            i2cm_pkg::OP_WRITE: begin
               if (phase_in == 2'd0) begin
                  sda_in_lvl = shift_in[7];
                  shift_in   = {shift_in[6:0], 1'b0};
               end else begin
                  scl_in = (phase_in == 2'd1);
               end
            end
            i2cm_pkg::OP_READ: begin
               if (idx_in == 5'd0) begin
                  sda_in_lvl = 1'b1;
               end else begin
                  unique case (phase_in)
                     2'd0:    scl_in = 1'b1;
                     2'd1:    shift_in = {shift_in[6:0], sda_in};
                     default: scl_in = 1'b0;
                  endcase
               end
            end
            i2cm_pkg::OP_SACK: begin
               if (idx_in == 5'd0) begin
                  sda_in_lvl = shift_in[0];
               end else begin
                  scl_in = (idx_in == 5'd1);
               end
            end
            i2cm_pkg::OP_RACK: begin
               unique case (idx_in)
                  5'd0:    sda_in_lvl = 1'b1;
                  5'd1:    scl_in = 1'b1;
                  5'd2:    ack_in = sda_in;
                  default: scl_in = 1'b0;
               endcase
            end
            default: begin
            end
         endcase
         // The read's leading release of SDA sits outside the three-phase bit cycle.
         if (!(cmd_in == i2cm_pkg::OP_READ && idx_in == 5'd0)) begin
            phase_in = (phase_in == 2'd2) ? 2'd0 : phase_in + 2'd1;
         end
         idx_in  = idx_in + 5'd1;
         hold_in = hold_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         cmd_ff   <= i2cm_pkg::OP_TICK;
         idx_ff   <= '0;
         phase_ff <= 2'd0;
         shift_ff <= 8'd0;
         hold_ff  <= '0;
         ack_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         rx_ff    <= 8'd0;
      end else if (step_en) begin
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         cmd_ff   <= cmd_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         hold_ff  <= hold_in;
         ack_ff   <= ack_in;
         busy_ff  <= busy_in;
         rx_ff    <= rx_in;
      end
   end

   always_comb begin
      result.scl_out  = scl_in;
      result.sda_out  = sda_in_lvl;
      result.busy_res = busy_in;
      result.done_res = done;
      result.rx_data  = rx_in;
      result.rx_ack   = ack_in;
   end

endmodule
